### rtl/count_tree_kth_select_top_defines.svh
// Assertion macros for the count tree k-th select block.
// Included by every RTL file that carries concurrent assertions; no other dependencies.
`ifndef COUNT_TREE_KTH_SELECT_TOP_DEFINES_SVH
`define COUNT_TREE_KTH_SELECT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define CTKS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition that must never be seen outside reset
`define CTKS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CTKS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CTKS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### rtl/ctks_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturating count helpers for the count tree k-th select block.
// No dependencies; used by the channel interfaces, the cells, the controller and the top level.
package ctks_pkg;

	localparam int MAX_LEAVES_DEF = 16384;

	localparam int OP_W   = 2;
	localparam int POS_W  = 15;
	localparam int RANK_W = 16;
	localparam int CNT_W  = 16;

	typedef logic [OP_W-1:0]   op_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// operation codes
	localparam op_t OP_CLEAR  = 2'd0;
	localparam op_t OP_INSERT = 2'd1;
	localparam op_t OP_SELECT = 2'd2;

	localparam pos_t LEAVES_RST = 15'd16384;
	localparam cnt_t CNT_MAX    = '1;

	// token walking down the cell chain: one tree node per cell
	typedef struct packed {
		logic  vld;
		logic  act;    // still descending; cleared once the result is settled
		op_t   op;
		pos_t  pos;
		pos_t  lo;     // range of the node being visited
		pos_t  hi;
		rank_t rank;   // rank left to find below this node
		logic  found;
		pos_t  idx;
	} tok_t;

	// new count of a node, travelling back up toward the root
	typedef struct packed {
		logic vld;
		cnt_t cnt;
	} up_t;

	// both children of one node, stored as one memory row
	typedef struct packed {
		cnt_t right_cnt;
		cnt_t left_cnt;
	} pair_t;

	function automatic cnt_t sat_inc(input cnt_t a);
		return (a == CNT_MAX) ? CNT_MAX : a + 1'b1;
	endfunction

	function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

endpackage

### rtl/ctks_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the query and answer items.
// Depends on ctks_pkg for field types.
interface ctks_query_if;
	logic               valid;
	logic               ready;
	ctks_pkg::op_t      op;
	ctks_pkg::pos_t     position;
	ctks_pkg::rank_t    rank;

	modport source (output valid, output op, output position, output rank, input ready);
	modport sink   (input valid, input op, input position, input rank, output ready);
endinterface

interface ctks_answer_if;
	logic           valid;
	logic           ready;
	logic           found;
	ctks_pkg::pos_t leaf_index;

	modport source (output valid, output found, output leaf_index, input ready);
	modport sink   (input valid, input found, input leaf_index, output ready);
endinterface

### rtl/ctks_cell.sv
`timescale 1ns / 1ps
// One tree level: memory of child count pairs for all nodes of level LEVEL-1, descent step,
// and the count rebuild on the way back up. Depends on ctks_pkg and the assertion macros.
`include "count_tree_kth_select_top_defines.svh"
module ctks_cell #(
	parameter int LEVEL = 1,
	parameter int PW    = 2,
	parameter int CW    = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctks_pkg::tok_t    tok_in,
	input  logic [PW-1:0]     p_in,
	input  ctks_pkg::up_t     up_in,
	input  logic              clr_en,
	input  logic [CW-1:0]     clr_addr,
	output ctks_pkg::tok_t    tok_out,
	output logic [PW-1:0]     p_out,
	output ctks_pkg::up_t     up_out
);

	localparam int AW    = (LEVEL > 1) ? LEVEL - 1 : 1;
	localparam int ROWS  = 2 ** AW;

	ctks_pkg::pair_t mem [ROWS];

	logic                   vld_q;
	logic                   up_vld_q;
	ctks_pkg::tok_t         tok_q;
	logic [PW-1:0]          p_q;
	ctks_pkg::pair_t        rd_q;
	ctks_pkg::cnt_t         up_cnt_q;

	logic [ctks_pkg::POS_W:0] sum;
	ctks_pkg::pos_t         mid;
	logic                   go_right;
	ctks_pkg::pos_t         nlo;
	ctks_pkg::pos_t         nhi;
	ctks_pkg::rank_t        rank_n;
	ctks_pkg::cnt_t         child_cnt;
	ctks_pkg::cnt_t         sibling;
	ctks_pkg::cnt_t         child_new;
	ctks_pkg::cnt_t         parent_new;
	logic                   leaf;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	ctks_pkg::pair_t        wr_data;

	// split point and child choice
	always_comb begin
		sum        = {1'b0, tok_q.lo} + {1'b0, tok_q.hi};
		mid        = sum[ctks_pkg::POS_W:1];
		if (tok_q.op == ctks_pkg::OP_INSERT) begin
			go_right = tok_q.pos > mid;
		end else begin
			go_right = tok_q.rank > rd_q.left_cnt;
		end
		nlo        = go_right ? mid + 1'b1 : tok_q.lo;
		nhi        = go_right ? tok_q.hi : mid;
		rank_n     = go_right ? tok_q.rank - rd_q.left_cnt : tok_q.rank;
		child_cnt  = go_right ? rd_q.right_cnt : rd_q.left_cnt;
		sibling    = go_right ? rd_q.left_cnt : rd_q.right_cnt;
		leaf       = nlo == nhi;
		// the cell that reaches the leaf bumps it itself; above it the new child count comes from below
		child_new  = leaf ? ctks_pkg::sat_inc(child_cnt) : up_in.cnt;
		parent_new = ctks_pkg::sat_add(child_new, sibling);
	end

	// token handed to the next level
	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = vld_q;
		if (tok_q.act) begin
			tok_out.lo   = nlo;
			tok_out.hi   = nhi;
			tok_out.rank = rank_n;
			if (tok_q.op == ctks_pkg::OP_SELECT) begin
				if (rank_n > child_cnt) begin
					tok_out.act   = 1'b0;
					tok_out.found = 1'b0;
					tok_out.idx   = '0;
				end else if (leaf) begin
					tok_out.act   = 1'b0;
					tok_out.found = 1'b1;
					tok_out.idx   = nlo;
				end
			end else if (leaf) begin
				tok_out.act = 1'b0;
			end
		end
	end

	assign p_out  = tok_q.act ? {p_q[PW-2:0], go_right} : p_q;
	assign up_out = '{vld: up_vld_q, cnt: up_cnt_q};

	// memory write: clearing sweep or count rebuild
	always_comb begin
		wr_en   = clr_en || (up_in.vld && tok_q.act);
		wr_addr = clr_en ? clr_addr[AW-1:0] : p_q[AW-1:0];
		if (clr_en) begin
			wr_data = '0;
		end else if (go_right) begin
			wr_data = '{right_cnt: child_new, left_cnt: sibling};
		end else begin
			wr_data = '{right_cnt: sibling, left_cnt: child_new};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read the pair together with taking the token
	always_ff @(posedge clk) begin
		if (tok_in.vld) begin
			rd_q <= mem[p_in[AW-1:0]];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= 1'b0;
			up_vld_q <= 1'b0;
		end else begin
			vld_q    <= tok_in.vld;
			up_vld_q <= up_in.vld;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (tok_in.vld) begin
			tok_q <= tok_in;
			p_q   <= p_in;
		end
		if (up_in.vld) begin
			up_cnt_q <= tok_q.act ? parent_new : up_in.cnt;
		end
	end

	`CTKS_ASSERT_NEVER(a_clr_quiet, clk, arst_n, clr_en && (tok_in.vld || up_in.vld), "cell busy during clear")
	`CTKS_ASSERT_NEVER(a_down_up_apart, clk, arst_n, tok_in.vld && up_in.vld, "descent and rebuild overlap")

endmodule

### rtl/ctks_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: takes query items, handles the root, launches the cell chain, runs the clearing
// sweep and holds the answer register. Depends on ctks_pkg, ctks_if and the assertion macros.
`include "count_tree_kth_select_top_defines.svh"
module ctks_ctrl #(
	parameter int MAX_LEAVES = ctks_pkg::MAX_LEAVES_DEF,
	parameter int CW         = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	ctks_query_if.sink        query,
	ctks_answer_if.source     answer,
	input  logic              cfg_we,
	input  ctks_pkg::pos_t    cfg_data,
	output ctks_pkg::tok_t    launch,
	input  ctks_pkg::tok_t    chain_res,
	output ctks_pkg::up_t     up_start,
	input  ctks_pkg::up_t     up_ret,
	output logic              clr_en,
	output logic [CW-1:0]     clr_addr
);

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;
	localparam logic [1:0] ST_RES  = 2'd3;

	logic [1:0]       state_q;
	logic [CW-1:0]    clr_cnt_q;
	ctks_pkg::pos_t   leaves_q;
	ctks_pkg::cnt_t   root_q;
	logic             res_found_q;
	ctks_pkg::pos_t   res_idx_q;
	logic             out_vld_q;
	logic             out_found_q;
	ctks_pkg::pos_t   out_idx_q;

	ctks_pkg::pos_t   span;
	logic             multi;
	logic             accept;
	logic             root_ok;
	logic             slot_free;

	// effective number of leaves
	always_comb begin
		if (leaves_q == '0) begin
			span = ctks_pkg::pos_t'(1);
		end else if (32'(leaves_q) > MAX_LEAVES) begin
			span = ctks_pkg::pos_t'(MAX_LEAVES);
		end else begin
			span = leaves_q;
		end
	end

	assign multi     = span != ctks_pkg::pos_t'(1);
	assign accept    = query.valid && query.ready;
	assign root_ok   = (query.rank != '0) && (query.rank <= root_q);
	assign slot_free = !out_vld_q || answer.ready;

	assign query.ready       = state_q == ST_IDLE;
	assign answer.valid      = out_vld_q;
	assign answer.found      = out_found_q;
	assign answer.leaf_index = out_idx_q;

	assign clr_en   = state_q == ST_CLR;
	assign clr_addr = clr_cnt_q;

	// descent starts at the root with the full range
	always_comb begin
		launch       = '0;
		launch.vld   = accept && multi && ((query.op == ctks_pkg::OP_INSERT) ||
			((query.op == ctks_pkg::OP_SELECT) && root_ok));
		launch.act   = 1'b1;
		launch.op    = query.op;
		launch.pos   = query.position;
		launch.lo    = ctks_pkg::pos_t'(1);
		launch.hi    = span;
		launch.rank  = query.rank;
	end

	// an insert reaching the bottom turns around
	assign up_start = '{vld: chain_res.vld && (chain_res.op == ctks_pkg::OP_INSERT), cnt: '0};

	// state, sweep counter, register, answer valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_cnt_q <= '0;
			leaves_q  <= ctks_pkg::LEAVES_RST;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				leaves_q <= cfg_data;
			end
			if (answer.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (&clr_cnt_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (query.op)
							ctks_pkg::OP_CLEAR: begin
								state_q   <= ST_CLR;
								clr_cnt_q <= '0;
							end
							ctks_pkg::OP_INSERT: begin
								if (multi) begin
									state_q <= ST_RUN;
								end
							end
							ctks_pkg::OP_SELECT: begin
								state_q <= (multi && root_ok) ? ST_RUN : ST_RES;
							end
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					if (chain_res.vld && (chain_res.op == ctks_pkg::OP_SELECT)) begin
						state_q <= ST_RES;
					end else if (up_ret.vld) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RES: begin
					if (slot_free) begin
						state_q   <= ST_IDLE;
						out_vld_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// root count and answer payload
	always_ff @(posedge clk) begin
		if (state_q == ST_CLR) begin
			root_q <= '0;
		end else if (up_ret.vld) begin
			root_q <= up_ret.cnt;
		end else if (accept && (query.op == ctks_pkg::OP_INSERT) && !multi) begin
			root_q <= ctks_pkg::sat_inc(root_q);
		end
		// answers settled at the root: rank missing, or a one-leaf tree
		if (accept) begin
			res_found_q <= root_ok;
			res_idx_q   <= root_ok ? ctks_pkg::pos_t'(1) : '0;
		end else if ((state_q == ST_RUN) && chain_res.vld) begin
			res_found_q <= chain_res.found;
			res_idx_q   <= chain_res.idx;
		end
		if ((state_q == ST_RES) && slot_free) begin
			out_found_q <= res_found_q;
			out_idx_q   <= res_idx_q;
		end
	end

	`CTKS_ASSERT(a_res_in_run, clk, arst_n, chain_res.vld |-> state_q == ST_RUN, "chain result while not running")
	`CTKS_ASSERT(a_ret_in_run, clk, arst_n, up_ret.vld |-> state_q == ST_RUN, "rebuild return while not running")
	`CTKS_ASSERT(a_answer_code, clk, arst_n, answer.valid |-> (answer.found == (answer.leaf_index != '0)), "found and index disagree")

endmodule

### rtl/count_tree_kth_select_top.sv
`timescale 1ns / 1ps
// Top level of the count tree k-th select block: controller plus one cell per tree level.
// Depends on ctks_pkg, ctks_if, ctks_cell and ctks_ctrl.
//
// Counting tree over positions 1..leaves_in_use with k-th mark select. The tree is a chain of
// LEVELS = clog2(MAX_LEAVES) cells, one per level, each owning the child count pairs of its
// level in a local memory; a query token moves one cell per cycle. One item is handled at a
// time: the next item is taken only once the previous one is through the chain and, for a
// select, its answer has moved into the output register. Insert walks down and rebuilds the
// counts on the way back up, one cell per cycle each way. With a single leaf, or a rank of
// zero or above the total, a select answer comes from the root. Clear, and the start after
// reset, run a sweep over the 2^(LEVELS-1) rows (8192 at default) of the deepest cell's
// memory, one row per cycle, clearing every cell's memory on the way, during which no item is
// taken; configuration writes are taken at any time. A finished answer waits in an output
// register while the next item is accepted.
module count_tree_kth_select_top #(
	parameter int MAX_LEAVES = ctks_pkg::MAX_LEAVES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	ctks_query_if.sink      query,
	ctks_answer_if.source   answer,
	input  logic            cfg_we,
	input  ctks_pkg::pos_t  cfg_data
);

	localparam int LEVELS = $clog2(MAX_LEAVES);
	localparam int PW     = LEVELS + 1;
	localparam int CW     = (LEVELS > 1) ? LEVELS - 1 : 1;

	ctks_pkg::tok_t   tok_c [0:LEVELS];
	logic [PW-1:0]    p_c   [0:LEVELS];
	ctks_pkg::up_t    up_c  [0:LEVELS];
	logic             clr_en;
	logic [CW-1:0]    clr_addr;

	assign p_c[0] = '0;

	// sequencer and root
	ctks_ctrl #(
		.MAX_LEAVES (MAX_LEAVES),
		.CW         (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.query     (query),
		.answer    (answer),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.launch    (tok_c[0]),
		.chain_res (tok_c[LEVELS]),
		.up_start  (up_c[LEVELS]),
		.up_ret    (up_c[0]),
		.clr_en    (clr_en),
		.clr_addr  (clr_addr)
	);

	// one cell per tree level
	for (genvar g = 1; g <= LEVELS; g++) begin : g_cell
		ctks_cell #(
			.LEVEL (g),
			.PW    (PW),
			.CW    (CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_in   (tok_c[g-1]),
			.p_in     (p_c[g-1]),
			.up_in    (up_c[g]),
			.clr_en   (clr_en),
			.clr_addr (clr_addr),
			.tok_out  (tok_c[g]),
			.p_out    (p_c[g]),
			.up_out   (up_c[g-1])
		);
	end

endmodule
